FILE: hw/rtl/lru_write_through_cache_defines.svh
// Assertion macros used by the cache top level.
`ifndef LRU_WRITE_THROUGH_CACHE_DEFINES_SVH
`define LRU_WRITE_THROUGH_CACHE_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define LWTC_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Check that post holds in the cycle after pre.
`define LWTC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/lwtc_pkg.sv
// Shared types and constants of the write-through cache.
package lwtc_pkg;

	localparam int LINES_DEF     = 8;
	localparam int MEM_WORDS_DEF = 1024;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 16;
	localparam int AGE_W  = 32;

	localparam logic [AGE_W-1:0]  AGE_RESET = 32'd1;
	localparam logic [AGE_W-1:0]  AGE_MAX   = 32'hFFFFFFFF;
	localparam logic [DATA_W-1:0] MEM_RESET = 16'hFFFF;

	localparam logic [1:0] CMD_READ      = 2'd0;
	localparam logic [1:0] CMD_WRITE     = 2'd1;
	localparam logic [1:0] CMD_EXT_WRITE = 2'd2;

	// One committed transaction as seen by the line store.
	typedef struct packed {
		logic commit;
		logic is_read;
		logic is_write;
		logic is_ext;
	} lwtc_op_t;

endpackage

FILE: hw/rtl/lwtc_ram.sv
// Generic single-port-write, registered-read RAM.
module lwtc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/lwtc_lines.sv
// Line store: valid, tag, age and data of each line, lookup and victim choice.
module lwtc_lines #(
	parameter int LINES = lwtc_pkg::LINES_DEF,
	parameter int TAG_W = $clog2(lwtc_pkg::MEM_WORDS_DEF)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lwtc_pkg::lwtc_op_t          op,
	input  logic [TAG_W-1:0]            addr,
	input  logic [lwtc_pkg::DATA_W-1:0] wdata,
	input  logic [lwtc_pkg::DATA_W-1:0] fill_word,
	output logic                        hit,
	output logic [lwtc_pkg::DATA_W-1:0] rd_word
);

	localparam int IW    = $clog2(LINES);
	localparam int LEAVES = 2 ** IW;
	localparam int NODES  = 2 * LEAVES - 1;
	localparam int KEY_W  = lwtc_pkg::AGE_W + 1;

	logic                        valid_q [LINES];
	logic [TAG_W-1:0]            tag_q   [LINES];
	logic [lwtc_pkg::AGE_W-1:0]  age_q   [LINES];
	logic [lwtc_pkg::DATA_W-1:0] word_q  [LINES];
	logic [lwtc_pkg::AGE_W-1:0]  age_ctr_q;
	logic [IW-1:0]               victim_q;

	logic [LINES-1:0] match;
	logic [IW-1:0]    hit_idx;
	logic [IW-1:0]    idx;
	logic             cached;

	logic [KEY_W-1:0] node_key [NODES];
	logic [IW-1:0]    node_idx [NODES];

	// Lookup: valid tags are unique, so the lowest match is the only one.
	always_comb begin
		hit_idx = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tag_q[i] == addr);
			if (match[i]) begin
				hit_idx = IW'(i);
			end
		end
	end

	assign hit     = |match;
	assign cached  = op.commit && (op.is_read || op.is_write);
	assign idx     = hit ? hit_idx : victim_q;
	assign rd_word = hit ? word_q[hit_idx] : fill_word;

	// Victim tree: an invalid line keys as zero, a valid one as its age above that.
	// Ties go left, so the lowest index wins; padding leaves key as the maximum.
	always_comb begin
		for (int i = 0; i < LEAVES; i++) begin
			if (i < LINES) begin
				node_key[LEAVES-1+i] = valid_q[i] ? {1'b1, age_q[i]} : '0;
			end else begin
				node_key[LEAVES-1+i] = {1'b1, lwtc_pkg::AGE_MAX};
			end
			node_idx[LEAVES-1+i] = IW'(i);
		end
		for (int n = LEAVES - 2; n >= 0; n--) begin
			if (node_key[2*n+1] <= node_key[2*n+2]) begin
				node_key[n] = node_key[2*n+1];
				node_idx[n] = node_idx[2*n+1];
			end else begin
				node_key[n] = node_key[2*n+2];
				node_idx[n] = node_idx[2*n+2];
			end
		end
	end

	// Line state only moves on a commit, and an accept must come between two commits,
	// so a registered victim is always current when it is used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_q  <= '0;
			age_ctr_q <= lwtc_pkg::AGE_RESET;
			for (int i = 0; i < LINES; i++) begin
				valid_q[i] <= 1'b0;
				tag_q[i]   <= '0;
				age_q[i]   <= '0;
			end
		end else begin
			victim_q <= node_idx[0];
			if (cached) begin
				age_ctr_q <= age_ctr_q + 1'b1;
			end
			for (int i = 0; i < LINES; i++) begin
				if (op.commit && op.is_ext && match[i]) begin
					valid_q[i] <= 1'b0;
				end
				if (cached && (idx == IW'(i))) begin
					valid_q[i] <= 1'b1;
					tag_q[i]   <= addr;
					age_q[i]   <= age_ctr_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LINES; i++) begin
			if (cached && (idx == IW'(i))) begin
				if (op.is_write) begin
					word_q[i] <= wdata;
				end else if (!hit) begin
					word_q[i] <= fill_word;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/lru_write_through_cache.sv
// Top level of the fully associative LRU write-through cache.
//
// Fully associative cache of LINES one-word lines in front of a MEM_WORDS-word
// backing memory, on stream ports. Each input transaction carries a command in
// s_tuser (read, write-through, or external write that invalidates a matching
// line) and an address and data word in s_tdata; each produces exactly one
// result transaction with the read word, a hit flag and an out-of-range flag.
// A read or write miss fills the first invalid line, else the line with the
// smallest age stamp (lowest index on a tie). After reset the backing memory is
// swept to 0xFFFF, one word a cycle, and s_tready stays low until the sweep
// ends. After that the accept edge issues the backing memory read, and the
// commit edge runs the lookup, updates lines and memory and loads the result
// register. A new transaction is taken while a result still waits on m_tready,
// and the work stage holds only while that result is not taken.
`include "lru_write_through_cache_defines.svh"

module lru_write_through_cache #(
	parameter int LINES     = lwtc_pkg::LINES_DEF,
	parameter int MEM_WORDS = lwtc_pkg::MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // word_address [15:0], write_word [31:16]
	input  logic [1:0]  s_tuser,   // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // read_word [15:0], was_hit [16], bad_address [17]
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [lwtc_pkg::ADDR_W:0] MEM_LIMIT = (lwtc_pkg::ADDR_W + 1)'(MEM_WORDS);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t  st_q;
	logic [AW-1:0] clr_q;

	// Work stage registers
	logic                          busy_s1;
	logic [1:0]                    cmd_s1;
	logic [lwtc_pkg::ADDR_W-1:0]   addr_s1;
	logic [lwtc_pkg::DATA_W-1:0]   wdata_s1;

	logic                          m_tvalid_q;
	logic [23:0]                   m_tdata_q;

	logic                          accept;
	logic                          out_free;
	logic                          commit;
	logic                          bad;
	logic                          known_cmd;
	logic                          is_read;
	logic                          is_write;
	logic                          is_ext;
	lwtc_pkg::lwtc_op_t            op;

	logic                          hit;
	logic [lwtc_pkg::DATA_W-1:0]   line_word;
	logic [lwtc_pkg::DATA_W-1:0]   mem_rdata;
	logic [lwtc_pkg::DATA_W-1:0]   rd_word;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [lwtc_pkg::DATA_W-1:0]   mem_wdata;

	// Take a new transaction only in run state with the work stage empty.
	assign s_tready = (st_q == ST_RUN) && !busy_s1;
	assign accept   = s_tvalid && s_tready;

	// Advance the work stage when the result register is free or being drained.
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = busy_s1 && out_free;

	// Decode the held transaction.
	assign is_read   = (cmd_s1 == lwtc_pkg::CMD_READ);
	assign is_write  = (cmd_s1 == lwtc_pkg::CMD_WRITE);
	assign is_ext    = (cmd_s1 == lwtc_pkg::CMD_EXT_WRITE);
	assign known_cmd = is_read || is_write || is_ext;
	assign bad       = known_cmd && ({1'b0, addr_s1} >= MEM_LIMIT);

	// Drop out-of-range and unknown commands before they reach the line store or the backing memory.
	assign op.commit   = commit && known_cmd && !bad;
	assign op.is_read  = is_read;
	assign op.is_write = is_write;
	assign op.is_ext   = is_ext;

	// The sweep owns the write port until it ends; after that, write-through
	// and external writes use it in the commit cycle.
	always_comb begin
		if (st_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = lwtc_pkg::MEM_RESET;
		end else begin
			mem_we    = op.commit && (is_write || is_ext);
			mem_waddr = addr_s1[AW-1:0];
			mem_wdata = wdata_s1;
		end
	end

	lwtc_ram #(
		.WIDTH(lwtc_pkg::DATA_W),
		.DEPTH(MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (s_tdata[AW-1:0]),
		.rdata (mem_rdata)
	);

	lwtc_lines #(
		.LINES(LINES),
		.TAG_W(AW)
	) u_lines (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.addr      (addr_s1[AW-1:0]),
		.wdata     (wdata_s1),
		.fill_word (mem_rdata),
		.hit       (hit),
		.rd_word   (line_word)
	);

	assign rd_word = (is_read && !bad) ? line_word : '0;

	// Reset sweep and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			busy_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					st_q <= ST_RUN;
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase

			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (commit) begin
				busy_s1 <= 1'b0;
			end

			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the transaction and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= s_tuser;
			addr_s1  <= s_tdata[15:0];
			wdata_s1 <= s_tdata[31:16];
		end
		if (commit) begin
			m_tdata_q <= {6'b0, bad, op.commit && !is_ext && hit, rd_word};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`LWTC_ASSERT_NEXT(a_accept_fills_stage, accept, busy_s1 && !s_tready, "accept did not occupy the work stage")
	`LWTC_ASSERT_NEXT(a_commit_gives_result, commit, m_tvalid, "commit did not load a result")
	`LWTC_ASSERT_SAME(a_bad_is_quiet, m_tvalid_q && m_tdata_q[17], m_tdata_q[16:0] == 17'd0, "bad address result carries data or hit")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the LRU write-through cache: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;
	import lwtc_pkg::*;

	localparam int NUM_LINES   = LINES_DEF;
	localparam int NUM_WORDS   = MEM_WORDS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RAND_PER_PHASE = 232;
	localparam int HOT_COUNT      = 12;
	// Covers the memory sweep after reset plus the worst stall, several times over.
	localparam int QUIET_LIMIT    = 4 * NUM_WORDS + 500;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic        bad_address;
		logic        was_hit;
		logic [15:0] read_word;
	} cache_result_t;

	typedef struct {
		logic [1:0]    cmd;
		logic [15:0]   addr;
		logic [15:0]   wdata;
		bit            typed;
		cache_result_t want;
	} row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;	// word_address [15:0], write_word [31:16]
	logic [1:0]  s_tuser  = CMD_READ;	// cmd [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;	// read_word [15:0], was_hit [16], bad_address [17]

	// Shadow copy of the cache and its backing memory
	logic          slot_valid [NUM_LINES];
	logic [15:0]   slot_tag   [NUM_LINES];
	logic [31:0]   slot_stamp [NUM_LINES];
	logic [15:0]   slot_word  [NUM_LINES];
	logic [15:0]   mem_image  [NUM_WORDS];
	logic [31:0]   stamp_next;

	cache_result_t pending_results [$];
	row_t          dir_rows [$];
	int            error_count    = 0;
	int            src_idle_pct   = 0;
	int            sink_stall_pct = 0;
	int unsigned   quiet_cycles   = 0;

	lru_write_through_cache #(
		.LINES     (NUM_LINES),
		.MEM_WORDS (NUM_WORDS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Apply one transaction to the shadow cache and return the result it must produce.
	function automatic cache_result_t predict_access(logic [1:0] cmd, logic [15:0] addr,
			logic [15:0] wdata);
		cache_result_t res;
		int            idx;
		logic [31:0]   oldest;
		res = '0;
		idx = -1;
		if (cmd == CMD_UNUSED)
			return res;
		if (addr >= NUM_WORDS) begin
			res.bad_address = 1'b1;
			return res;
		end
		for (int i = 0; i < NUM_LINES; i++) begin
			if (idx < 0 && slot_valid[i] && slot_tag[i] == addr)
				idx = i;
		end
		if (cmd == CMD_EXT_WRITE) begin
			// Memory takes the word; a cached copy is invalidated, keep its stamp
			mem_image[addr] = wdata;
			if (idx >= 0)
				slot_valid[idx] = 1'b0;
			return res;
		end
		if (idx >= 0) begin
			res.was_hit = 1'b1;
		end else begin
			// Take the first free line, else the oldest stamp (lowest index wins a tie)
			for (int i = 0; i < NUM_LINES; i++) begin
				if (idx < 0 && !slot_valid[i])
					idx = i;
			end
			if (idx < 0) begin
				idx    = 0;
				oldest = slot_stamp[0];
				for (int i = 1; i < NUM_LINES; i++) begin
					if (slot_stamp[i] < oldest) begin
						oldest = slot_stamp[i];
						idx    = i;
					end
				end
			end
			slot_word[idx]  = mem_image[addr];
			slot_tag[idx]   = addr;
			slot_valid[idx] = 1'b1;
		end
		if (cmd == CMD_READ) begin
			res.read_word = slot_word[idx];
		end else begin
			slot_word[idx]  = wdata;
			mem_image[addr] = wdata;
		end
		slot_stamp[idx] = stamp_next;
		stamp_next      = stamp_next + 32'd1;
		return res;
	endfunction

	function automatic void add_row(logic [1:0] cmd, logic [15:0] addr, logic [15:0] wdata,
			bit typed, logic [15:0] rword, logic hit, logic bad);
		row_t r;
		r.cmd   = cmd;
		r.addr  = addr;
		r.wdata = wdata;
		r.typed = typed;
		r.want  = '{bad_address: bad, was_hit: hit, read_word: rword};
		dir_rows.push_back(r);
	endfunction

	// Present one transaction, hold it until taken, then record what must come back.
	task automatic send_access(logic [1:0] cmd, logic [15:0] addr, logic [15:0] wdata,
			bit typed, cache_result_t typed_res);
		cache_result_t model_res;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {wdata, addr};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		// Predictor always advances; typed rows override only the compared value
		model_res = predict_access(cmd, addr, wdata);
		pending_results.push_back(typed ? typed_res : model_res);
	endtask

	// Hold off the sender until every outstanding result has drained.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Receiver backpressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Compare every result transaction against the oldest expectation
	always @(posedge clk) begin
		cache_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction: m_tdata %h", m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.read_word) begin
					$error("read_word: expected %h, got %h", want.read_word, m_tdata[15:0]);
					error_count++;
				end
				if (m_tdata[16] !== want.was_hit) begin
					$error("was_hit: expected %b, got %b", want.was_hit, m_tdata[16]);
					error_count++;
				end
				if (m_tdata[17] !== want.bad_address) begin
					$error("bad_address: expected %b, got %b", want.bad_address, m_tdata[17]);
					error_count++;
				end
			end
		end
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [15:0]   hot_addr [HOT_COUNT];
		logic [1:0]    cmd;
		logic [15:0]   addr;
		logic [15:0]   wdata;
		int            pick;
		cache_result_t none;

		none = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			slot_valid[i] = 1'b0;
			slot_tag[i]   = '0;
			slot_stamp[i] = '0;
			slot_word[i]  = '0;
		end
		for (int i = 0; i < NUM_WORDS; i++)
			mem_image[i] = MEM_RESET;
		stamp_next = AGE_RESET;

		// Small hot set, larger than the cache, so hits and evictions both occur
		hot_addr[0] = '0;
		hot_addr[1] = 16'(NUM_WORDS - 1);
		for (int i = 2; i < HOT_COUNT; i++)
			hot_addr[i] = 16'($urandom_range(NUM_WORDS - 1));

		// Directed table: cold misses, range limits, unused command, hit, write-through,
		// external write invalidating a line, filling every line, then LRU eviction.
		add_row(CMD_READ,      16'd0,           16'h0000, 1, MEM_RESET, 0, 0);
		add_row(CMD_READ,      16'(NUM_WORDS-1), 16'h0000, 1, MEM_RESET, 0, 0);
		add_row(CMD_READ,      16'(NUM_WORDS),   16'h0000, 1, 16'h0000,  0, 1);
		add_row(CMD_WRITE,     16'hFFFF,        16'hFFFF, 1, 16'h0000,  0, 1);
		add_row(CMD_EXT_WRITE, 16'hFFFF,        16'h5A5A, 1, 16'h0000,  0, 1);
		add_row(CMD_UNUSED,    16'd5,           16'h1234, 1, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd0,           16'h0000, 1, MEM_RESET, 1, 0);
		add_row(CMD_WRITE,     16'd0,           16'h0000, 1, 16'h0000,  1, 0);
		add_row(CMD_READ,      16'd0,           16'hFFFF, 0, 16'h0000,  0, 0);
		add_row(CMD_WRITE,     16'd2,           16'hA5A5, 1, 16'h0000,  0, 0);
		add_row(CMD_EXT_WRITE, 16'd0,           16'h1234, 1, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd0,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd3,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_WRITE,     16'd4,           16'h8001, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd5,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_WRITE,     16'd6,           16'h7FFE, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd7,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd9,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'(NUM_WORDS-1), 16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd2,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_EXT_WRITE, 16'd5,           16'hBEEF, 0, 16'h0000,  0, 0);
		add_row(CMD_WRITE,     16'd10,          16'hC3C3, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd5,           16'h0000, 0, 16'h0000,  0, 0);
		add_row(CMD_READ,      16'd10,          16'h0000, 0, 16'h0000,  0, 0);

		// Hold reset, then release it; the block then sweeps its memory with s_tready low
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_access(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].wdata,
				dir_rows[i].typed, dir_rows[i].want);
		drain_results();

		// Random traffic over four pressure phases. Stamp wraparound needs 2^32
		// accesses and stays out of reach here.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
				default: begin src_idle_pct = 7; sink_stall_pct = 7; end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 3)
					cmd = CMD_UNUSED;
				else if (pick < 53)
					cmd = CMD_READ;
				else if (pick < 83)
					cmd = CMD_WRITE;
				else
					cmd = CMD_EXT_WRITE;
				pick = $urandom_range(99);
				if (pick < 5)
					addr = 16'($urandom_range(16'hFFFF, NUM_WORDS));
				else if (pick < 75)
					addr = hot_addr[$urandom_range(HOT_COUNT - 1)];
				else
					addr = 16'($urandom_range(NUM_WORDS - 1));
				wdata = 16'($urandom_range(16'hFFFF));
				send_access(cmd, addr, wdata, 0, none);
			end
			drain_results();
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: lru_write_through_cache.f
+incdir+hw/rtl
hw/rtl/lwtc_pkg.sv
hw/rtl/lwtc_ram.sv
hw/rtl/lwtc_lines.sv
hw/rtl/lru_write_through_cache.sv
bench/tb_top.sv
